// ===== rtl/core/bsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfc_pkg: shared types and constants of the byte stuffing frame codec
// Escape codes, register indexes, reset values and the result item record.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned MAX_RES   = 4;
   localparam int unsigned CNT_W     = $clog2(MAX_RES + 1);
   localparam int unsigned SLOT_W    = $clog2(MAX_RES);
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // second byte of an escape pair
   localparam logic [BYTE_W-1:0] CODE_ESCAPE = 8'h00;
   localparam logic [BYTE_W-1:0] CODE_BEGIN  = 8'h01;
   localparam logic [BYTE_W-1:0] CODE_END    = 8'h02;

   localparam logic [BYTE_W-1:0] RST_BEGIN_MARKER = 8'hFF;
   localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'hFE;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'hFD;

   typedef enum logic [1:0] {
      REG_DECODE_MODE  = 2'd0,
      REG_BEGIN_MARKER = 2'd1,
      REG_END_MARKER   = 2'd2,
      REG_ESCAPE_BYTE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              byte_valid;
      logic              frame_done;
      logic              frame_error;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/byte_stuffing_frame_codec.sv =====
// ----------------------------------------------------------------------------
// byte_stuffing_frame_codec: byte stuffing frame encoder / decoder
// Wraps raw frames with begin/end markers and escape pairs, or unwraps them.
// ----------------------------------------------------------------------------
// One byte comes in per req item, tagged with frame_last. An accepted item
// is expanded in the same cycle into its whole list of result items (zero
// to four) and parked in a small result buffer; the buffer feeds the rsp
// output register one item per cycle unless rsp_stall holds it. A new req
// item is taken once the buffer is empty or its final entry moves to the
// output register, so a byte that causes several results holds off the
// next byte until they are handed out; plain bytes run at one per cycle
// while rsp_stall stays low.
// Registers (APB, byte address 4*i): decode_mode, begin_marker, end_marker,
// escape_byte. Change them only while the block is idle.
`default_nettype none

module byte_stuffing_frame_codec (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bsfc_pkg::BYTE_W-1:0]         req_in_byte,
   input  wire logic                                req_frame_last,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [bsfc_pkg::BYTE_W-1:0]              rsp_out_byte,
   output logic                                     rsp_byte_valid,
   output logic                                     rsp_frame_done,
   output logic                                     rsp_frame_error,
   output logic                                     rsp_run_last,
   // configuration
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [bsfc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [bsfc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bsfc_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   import bsfc_pkg::*;

   // ---------------------------------------------------------------- CSRs
   logic              decode_mode_ff;
   logic [BYTE_W-1:0] begin_marker_ff;
   logic [BYTE_W-1:0] end_marker_ff;
   logic [BYTE_W-1:0] escape_byte_ff;

   reg_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff  <= 1'b0;
         begin_marker_ff <= RST_BEGIN_MARKER;
         end_marker_ff   <= RST_END_MARKER;
         escape_byte_ff  <= RST_ESCAPE_BYTE;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DECODE_MODE:  decode_mode_ff  <= pwdata[0];
            REG_BEGIN_MARKER: begin_marker_ff <= pwdata[BYTE_W-1:0];
            REG_END_MARKER:   end_marker_ff   <= pwdata[BYTE_W-1:0];
            REG_ESCAPE_BYTE:  escape_byte_ff  <= pwdata[BYTE_W-1:0];
            default:          decode_mode_ff  <= decode_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DECODE_MODE:  prdata = {{(CSR_DATA_W-1){1'b0}}, decode_mode_ff};
         REG_BEGIN_MARKER: prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, begin_marker_ff};
         REG_END_MARKER:   prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, end_marker_ff};
         REG_ESCAPE_BYTE:  prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, escape_byte_ff};
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- frame state
   logic at_frame_start_ff, at_frame_start_in;
   logic escape_pending_ff, escape_pending_in;
   logic start_bad_ff,      start_bad_in;

   // result buffer: slot 0 is always the next item to hand out
   result_type       buf_ff [MAX_RES];
   result_type       buf_in [MAX_RES];
   logic [CNT_W-1:0] buf_cnt_ff, buf_cnt_in;

   // output register
   logic       rsp_valid_ff;
   result_type rsp_res_ff;
   logic       rsp_run_last_ff;

   logic req_accept, buf_move, out_free;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign buf_move   = (buf_cnt_ff != '0) & out_free;
   // free once empty, or when the final buffered item leaves this cycle
   assign req_stall  = ~((buf_cnt_ff == '0) |
                         ((buf_cnt_ff == CNT_W'(1)) & buf_move));
   assign req_accept = req_valid & ~req_stall;

   // --------------------------------------------- expansion of one item
   result_type        list [MAX_RES];
   logic [CNT_W-1:0]  n_res;
   logic              is_code;
   logic              is_escape;
   logic              end_bad;
   logic [BYTE_W-1:0] b;
   logic              last;

   assign b         = req_in_byte;
   assign last      = req_frame_last;
   assign is_code   = (b == CODE_ESCAPE) || (b == CODE_BEGIN) || (b == CODE_END);
   assign is_escape = (b == escape_byte_ff);
   assign end_bad   = (b != end_marker_ff);

   always_comb begin
      for (int i = 0; i < MAX_RES; i++) begin
         list[i] = '0;
      end
      n_res             = '0;
      at_frame_start_in = at_frame_start_ff;
      escape_pending_in = escape_pending_ff;
      start_bad_in      = start_bad_ff;

      if (!decode_mode_ff) begin
         // encode: [begin] byte-or-pair [end]
         if (at_frame_start_ff) begin
            list[n_res[SLOT_W-1:0]] = '{begin_marker_ff, 1'b1, 1'b0, 1'b0};
            n_res = n_res + CNT_W'(1);
            at_frame_start_in = 1'b0;
         end
         priority if (is_escape) begin
            list[n_res[SLOT_W-1:0]] = '{escape_byte_ff, 1'b1, 1'b0, 1'b0};
            list[n_res[SLOT_W-1:0] + SLOT_W'(1)] = '{CODE_ESCAPE, 1'b1, 1'b0, 1'b0};
            n_res = n_res + CNT_W'(2);
         end else if (b == end_marker_ff) begin
            list[n_res[SLOT_W-1:0]] = '{escape_byte_ff, 1'b1, 1'b0, 1'b0};
            list[n_res[SLOT_W-1:0] + SLOT_W'(1)] = '{CODE_END, 1'b1, 1'b0, 1'b0};
            n_res = n_res + CNT_W'(2);
         end else if (b == begin_marker_ff) begin
            list[n_res[SLOT_W-1:0]] = '{escape_byte_ff, 1'b1, 1'b0, 1'b0};
            list[n_res[SLOT_W-1:0] + SLOT_W'(1)] = '{CODE_BEGIN, 1'b1, 1'b0, 1'b0};
            n_res = n_res + CNT_W'(2);
         end else begin
            list[n_res[SLOT_W-1:0]] = '{b, 1'b1, 1'b0, 1'b0};
            n_res = n_res + CNT_W'(1);
         end
         if (last) begin
            list[n_res[SLOT_W-1:0]] = '{end_marker_ff, 1'b1, 1'b1, 1'b0};
            n_res = n_res + CNT_W'(1);
         end
      end else begin
         priority if (at_frame_start_ff) begin
            // opening byte is only checked
            start_bad_in      = (b != begin_marker_ff);
            at_frame_start_in = 1'b0;
            if (last) begin
               list[0] = '{'0, 1'b0, 1'b1, (b != begin_marker_ff) | end_bad};
               n_res   = CNT_W'(1);
            end
         end else if (last) begin
            // dangling escape before a non-code closing byte still goes out
            if (escape_pending_ff && !is_code) begin
               list[0] = '{escape_byte_ff, 1'b1, 1'b0, 1'b0};
               n_res   = CNT_W'(1);
            end
            list[n_res[SLOT_W-1:0]] = '{'0, 1'b0, 1'b1, start_bad_ff | end_bad};
            n_res = n_res + CNT_W'(1);
         end else if (escape_pending_ff && is_code) begin
            escape_pending_in = 1'b0;
            n_res = CNT_W'(1);
            unique case (b)
               CODE_ESCAPE: list[0] = '{escape_byte_ff,  1'b1, 1'b0, 1'b0};
               CODE_BEGIN:  list[0] = '{begin_marker_ff, 1'b1, 1'b0, 1'b0};
               default:     list[0] = '{end_marker_ff,   1'b1, 1'b0, 1'b0};
            endcase
         end else begin
            // broken pair: the escape goes out, then the byte as usual
            if (escape_pending_ff) begin
               list[0] = '{escape_byte_ff, 1'b1, 1'b0, 1'b0};
               n_res   = CNT_W'(1);
            end
            escape_pending_in = is_escape;
            if (!is_escape) begin
               list[n_res[SLOT_W-1:0]] = '{b, 1'b1, 1'b0, 1'b0};
               n_res = n_res + CNT_W'(1);
            end
         end
      end

      if (last) begin
         at_frame_start_in = 1'b1;
         escape_pending_in = 1'b0;
         start_bad_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_frame_start_ff <= 1'b1;
         escape_pending_ff <= 1'b0;
         start_bad_ff      <= 1'b0;
      end else if (req_accept) begin
         at_frame_start_ff <= at_frame_start_in;
         escape_pending_ff <= escape_pending_in;
         start_bad_ff      <= start_bad_in;
      end
   end

   // ------------------------------------------------------ result buffer
   always_comb begin
      buf_cnt_in = buf_cnt_ff;
      for (int i = 0; i < MAX_RES; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (req_accept) begin
         buf_cnt_in = n_res;
         for (int i = 0; i < MAX_RES; i++) begin
            buf_in[i] = list[i];
         end
      end else if (buf_move) begin
         buf_cnt_in = buf_cnt_ff - CNT_W'(1);
         for (int i = 0; i < MAX_RES - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= '0;
      end else begin
         buf_cnt_ff <= buf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   // ---------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (buf_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_move) begin
         rsp_res_ff      <= buf_ff[0];
         rsp_run_last_ff <= (buf_cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_res_ff.data;
   assign rsp_byte_valid  = rsp_res_ff.byte_valid;
   assign rsp_frame_done  = rsp_res_ff.frame_done;
   assign rsp_frame_error = rsp_res_ff.frame_error;
   assign rsp_run_last    = rsp_run_last_ff;

`ifndef NO_ASSERTIONS
   // buffer never holds more than one item's worth of results
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      buf_cnt_ff <= CNT_W'(MAX_RES))
      else $error("result buffer count out of range");

   // frame closing result is always the final result of its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.frame_done |-> rsp_run_last_ff)
      else $error("frame_done on a result that is not run_last");

   // error flag only on a status result
   a_err_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.frame_error |->
         rsp_res_ff.frame_done && !rsp_res_ff.byte_valid)
      else $error("frame_error outside a status result");

   // no escape can be pending and no bad start flagged before a frame has started
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      at_frame_start_ff |-> !escape_pending_ff && !start_bad_ff)
      else $error("stale decode state at frame start");

   // an accepted item replaces the buffer only once it is empty or its final entry leaves
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (buf_cnt_ff == '0) || (buf_cnt_ff == CNT_W'(1) && buf_move))
      else $error("item accepted over pending results");
`endif

endmodule

`default_nettype wire

// ===== sim/byte_stuffing_frame_codec_test.sv =====
// ----------------------------------------------------------------------------
// byte_stuffing_frame_codec_test: self-checking bench for the frame codec
// Drives bytes with random gaps and back-pressure, predicts result items from
// a behavioral copy of the encoder/decoder or a typed list, checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffing_frame_codec_test;
   import bsfc_pkg::*;

   // result item as seen on the rsp channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_done;
      logic       frame_error;
      logic       run_last;
   } codec_result_type;

   // one directed stimulus row; n_typed > 0 means the results are spelled out
   typedef struct packed {
      logic                     mode;
      logic [7:0]               in_byte;
      logic                     last;
      logic [2:0]               n_typed;
      codec_result_type [0:3]   typed;
   } directed_row_type;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // flag nibbles {byte_valid, frame_done, frame_error, run_last}
   localparam logic [3:0] F_DATA       = 4'b1000;
   localparam logic [3:0] F_CLOSE      = 4'b1101;
   localparam logic [3:0] F_STATUS_OK  = 4'b0101;
   localparam logic [3:0] F_STATUS_BAD = 4'b0111;

   localparam codec_result_type        NO_RESULT = '0;
   localparam codec_result_type [0:3]  NO_TYPED  = '0;

   localparam int N_DIRECTED     = 27;
   localparam int N_PHASES       = 8;
   localparam int PHASE_ITEMS    = 56;
   localparam int SETTLE_CYCLES  = 8;    // covers items that leave no result
   localparam int WATCHDOG_LIMIT = 1000;

   // Directed part runs with the reset marker values (begin FF, end FE,
   // escape FD). Rows with a typed result list are checked against that list.
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // encode, one-byte frame: begin marker, the byte, end marker
      '{MODE_ENCODE, 8'h41, 1'b1, 3'd3, '{{RST_BEGIN_MARKER, F_DATA}, {8'h41, F_DATA},
         {RST_END_MARKER, F_CLOSE}, NO_RESULT}},
      // encode, begin byte as data: the widest item, four results
      '{MODE_ENCODE, RST_BEGIN_MARKER, 1'b1, 3'd4, '{{RST_BEGIN_MARKER, F_DATA},
         {RST_ESCAPE_BYTE, F_DATA}, {CODE_BEGIN, F_DATA}, {RST_END_MARKER, F_CLOSE}}},
      '{MODE_ENCODE, 8'h00,            1'b0, 3'd0, NO_TYPED},
      '{MODE_ENCODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_ENCODE, RST_END_MARKER,   1'b0, 3'd0, NO_TYPED},
      '{MODE_ENCODE, RST_BEGIN_MARKER, 1'b0, 3'd0, NO_TYPED},
      '{MODE_ENCODE, 8'h80,            1'b1, 3'd0, NO_TYPED},
      // decode: good begin, then each escape pair
      '{MODE_DECODE, RST_BEGIN_MARKER, 1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, CODE_ESCAPE,      1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, CODE_BEGIN,       1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, CODE_END,         1'b0, 3'd0, NO_TYPED},
      // escape then an ordinary byte
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, 8'h33,            1'b0, 3'd0, NO_TYPED},
      // escape then escape: second one opens a new pair
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, CODE_ESCAPE,      1'b0, 3'd0, NO_TYPED},
      // pending escape on the closing byte: escape is flushed, clean status
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_END_MARKER,   1'b1, 3'd2, '{{RST_ESCAPE_BYTE, F_DATA},
         {8'h00, F_STATUS_OK}, NO_RESULT, NO_RESULT}},
      // one-byte frame, wrong markers
      '{MODE_DECODE, 8'h00,            1'b1, 3'd1, '{{8'h00, F_STATUS_BAD}, NO_RESULT,
         NO_RESULT, NO_RESULT}},
      // bad begin, pair dropped with the closing code byte
      '{MODE_DECODE, 8'h80,            1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_ESCAPE_BYTE,  1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, CODE_BEGIN,       1'b1, 3'd1, '{{8'h00, F_STATUS_BAD}, NO_RESULT,
         NO_RESULT, NO_RESULT}},
      // empty payload between good markers
      '{MODE_DECODE, RST_BEGIN_MARKER, 1'b0, 3'd0, NO_TYPED},
      '{MODE_DECODE, RST_END_MARKER,   1'b1, 3'd1, '{{8'h00, F_STATUS_OK}, NO_RESULT,
         NO_RESULT, NO_RESULT}}
   };

   // DUT-facing signals; those the bench drives are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   wire logic             req_stall;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  req_frame_last = 1'b0;
   wire logic             rsp_valid;
   logic                  rsp_stall = 1'b0;
   wire logic [BYTE_W-1:0] rsp_out_byte;
   wire logic             rsp_byte_valid;
   wire logic             rsp_frame_done;
   wire logic             rsp_frame_error;
   wire logic             rsp_run_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   wire logic [CSR_DATA_W-1:0] prdata;
   wire logic             pready;

   // shadow of the registers and the codec's frame state
   logic       cfg_decode = MODE_ENCODE;
   logic [7:0] cfg_begin  = RST_BEGIN_MARKER;
   logic [7:0] cfg_end    = RST_END_MARKER;
   logic [7:0] cfg_escape = RST_ESCAPE_BYTE;
   logic       at_frame_start = 1'b1;
   logic       esc_pending = 1'b0;
   logic       start_bad = 1'b0;

   codec_result_type codec_step_out[$];     // results of the byte just taken
   codec_result_type codec_results_due[$];  // results still owed by the block

   logic        no_idle = 1'b0;   // burst stretch: neither side idles
   int unsigned rsp_hold = 0;     // stall cycles left before the next result
   int unsigned idle_cycles = 0;
   int          error_count = 0;

   byte_stuffing_frame_codec u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void out_data(input logic [7:0] b);
      codec_step_out.push_back({b, F_DATA});
   endfunction

   function automatic void out_status(input logic bad);
      codec_step_out.push_back({8'h00, 1'b0, 1'b1, bad, 1'b0});
   endfunction

   function automatic void frame_reset();
      at_frame_start = 1'b1;
      esc_pending    = 1'b0;
      start_bad      = 1'b0;
   endfunction

   function automatic void predict_codec(input logic [7:0] b, input logic last);
      logic is_code;
      logic plain;
      codec_step_out.delete();
      is_code = (b == CODE_ESCAPE) || (b == CODE_BEGIN) || (b == CODE_END);
      if (cfg_decode == MODE_ENCODE) begin
         if (at_frame_start) begin
            out_data(cfg_begin);
            at_frame_start = 1'b0;
         end
         // escape, end, begin: tested in that order
         if (b == cfg_escape) begin
            out_data(cfg_escape);
            out_data(CODE_ESCAPE);
         end else if (b == cfg_end) begin
            out_data(cfg_escape);
            out_data(CODE_END);
         end else if (b == cfg_begin) begin
            out_data(cfg_escape);
            out_data(CODE_BEGIN);
         end else begin
            out_data(b);
         end
         if (last) begin
            codec_step_out.push_back({cfg_end, F_CLOSE});
            frame_reset();
         end
      end else if (at_frame_start) begin
         // opening byte is only checked; a one-byte frame checks both markers
         start_bad      = (b != cfg_begin);
         at_frame_start = 1'b0;
         if (last) begin
            out_status(start_bad || (b != cfg_end));
            frame_reset();
         end
      end else if (last) begin
         // a pending escape survives only if the closer is not a code byte
         if (esc_pending && !is_code)
            out_data(cfg_escape);
         out_status(start_bad || (b != cfg_end));
         frame_reset();
      end else begin
         plain = 1'b1;
         if (esc_pending) begin
            esc_pending = 1'b0;
            plain = 1'b0;
            if (b == CODE_ESCAPE)
               out_data(cfg_escape);
            else if (b == CODE_BEGIN)
               out_data(cfg_begin);
            else if (b == CODE_END)
               out_data(cfg_end);
            else begin
               out_data(cfg_escape);
               plain = 1'b1;
            end
         end
         if (plain) begin
            if (b == cfg_escape)
               esc_pending = 1'b1;
            else
               out_data(b);
         end
      end
      if (codec_step_out.size() != 0)
         codec_step_out[codec_step_out.size() - 1].run_last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Offers one byte after a random gap and books its results on acceptance.
   task automatic push_byte(input logic [7:0] b, input logic last,
                            input logic [2:0] n_typed,
                            input codec_result_type [0:3] typed);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_frame_last <= last;
      do @(posedge clock); while (req_stall);
      predict_codec(b, last);
      if (n_typed != 0) begin
         for (int i = 0; i < n_typed; i++)
            codec_results_due.push_back(typed[i]);
      end else begin
         foreach (codec_step_out[i])
            codec_results_due.push_back(codec_step_out[i]);
      end
   endtask

   // Drops valid and waits until every owed result is out, plus a margin
   // for a trailing item that produces nothing.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (codec_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers back to back; psel stays up between writes.
   // Upper data bits carry junk, the block must mask them off.
   task automatic load_config(input logic mode, input logic [7:0] bgn,
                              input logic [7:0] fin, input logic [7:0] esc);
      logic [7:0]  vals [4];
      logic [31:0] keep;
      vals[REG_DECODE_MODE]  = {7'd0, mode};
      vals[REG_BEGIN_MARKER] = bgn;
      vals[REG_END_MARKER]   = fin;
      vals[REG_ESCAPE_BYTE]  = esc;
      for (int i = REG_DECODE_MODE; i <= REG_ESCAPE_BYTE; i++) begin
         keep = (reg_index_type'(i) == REG_DECODE_MODE) ? 32'h1 : 32'hFF;
         @(negedge clock);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {2'(i), 2'b00};
         pwdata  <= ($urandom() & ~keep) | (32'(vals[i]) & keep);
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_decode = mode;
      cfg_begin  = bgn;
      cfg_end    = fin;
      cfg_escape = esc;
   endtask

   // data bytes lean toward the markers and the pair codes
   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(0, 7))
         0: return cfg_begin;
         1: return cfg_end;
         2: return cfg_escape;
         3: return CODE_ESCAPE;
         4: return CODE_BEGIN;
         5: return CODE_END;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] pick_marker();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return CODE_END;
         default: return 8'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Receiver side: stall per result, drawn when the previous one is taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker and watchdog. The watchdog counts cycles in which
   // neither channel moves an item.
   always @(posedge clock) begin
      codec_result_type got;
      codec_result_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_byte, rsp_byte_valid, rsp_frame_done, rsp_frame_error,
                   rsp_run_last};
            if (codec_results_due.size() == 0) begin
               $error("unexpected result item: out_byte %h flags %b", got.out_byte,
                      got[3:0]);
               error_count++;
            end else begin
               want = codec_results_due.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                  error_count++;
               end
               if (got.byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, got %b", want.byte_valid,
                         got.byte_valid);
                  error_count++;
               end
               if (got.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %b, got %b", want.frame_done,
                         got.frame_done);
                  error_count++;
               end
               if (got.frame_error !== want.frame_error) begin
                  $error("frame_error: expected %b, got %b", want.frame_error,
                         got.frame_error);
                  error_count++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                  error_count++;
               end
            end
            rsp_hold = no_idle ? 0 : $urandom_range(0, 10);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int         phase_items;
      int         raw_len;
      logic [7:0] raw;
      logic [7:0] frame_bytes[$];

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows, reset marker values. A mode change waits for idle.
      for (int r = 0; r < N_DIRECTED; r++) begin
         if (DIRECTED_ROWS[r].mode != cfg_decode) begin
            drain_results();
            load_config(DIRECTED_ROWS[r].mode, cfg_begin, cfg_end, cfg_escape);
         end
         no_idle = ($urandom_range(0, 3) == 0);
         push_byte(DIRECTED_ROWS[r].in_byte, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].n_typed, DIRECTED_ROWS[r].typed);
      end

      // Random phases. The first four use fixed extreme settings, the rest
      // draw them. A phase may stop mid-frame, so the next one can switch
      // mode with the frame state left open.
      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         case (p)
            0: load_config(MODE_ENCODE, 8'h00, 8'hFF, 8'h80);
            1: load_config(MODE_DECODE, 8'h00, 8'hFF, 8'h80);
            2: load_config(MODE_DECODE, CODE_END, CODE_END, CODE_END);
            3: load_config(MODE_ENCODE, CODE_END, CODE_END, CODE_END);
            default: load_config(1'($urandom_range(0, 1)), pick_marker(), pick_marker(),
                                 pick_marker());
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            frame_bytes.delete();
            raw_len = $urandom_range(1, 6);
            if (cfg_decode == MODE_ENCODE || $urandom_range(0, 7) == 0) begin
               // raw frame for the encoder, or line noise for the decoder
               for (int k = 0; k < raw_len; k++)
                  frame_bytes.push_back(pick_data_byte());
            end else begin
               // well-formed encoded frame, now and then with one byte hit
               frame_bytes.push_back(cfg_begin);
               for (int k = 0; k < raw_len; k++) begin
                  raw = pick_data_byte();
                  if (raw == cfg_escape) begin
                     frame_bytes.push_back(cfg_escape);
                     frame_bytes.push_back(CODE_ESCAPE);
                  end else if (raw == cfg_end) begin
                     frame_bytes.push_back(cfg_escape);
                     frame_bytes.push_back(CODE_END);
                  end else if (raw == cfg_begin) begin
                     frame_bytes.push_back(cfg_escape);
                     frame_bytes.push_back(CODE_BEGIN);
                  end else begin
                     frame_bytes.push_back(raw);
                  end
               end
               frame_bytes.push_back(cfg_end);
               if ($urandom_range(0, 4) == 0)
                  frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom());
            end
            no_idle = ($urandom_range(0, 3) == 0);
            foreach (frame_bytes[i]) begin
               if (phase_items == PHASE_ITEMS)
                  break;
               push_byte(frame_bytes[i], (i == frame_bytes.size() - 1), 3'd0, NO_TYPED);
               phase_items++;
            end
            // now and then the sender holds off until the block has drained
            if ($urandom_range(0, 9) == 0)
               drain_results();
         end
      end

      drain_results();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/bsfc_pkg.sv
rtl/core/byte_stuffing_frame_codec.sv
sim/byte_stuffing_frame_codec_test.sv
